@@ sv/uvs_pkg.sv @@
// shared types and constants for the unique value stack
// no dependencies; compile first

package uvs_pkg;

   localparam int DEPTH  = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int DATA_W = 32;
   localparam int CAP_W  = 11;
   localparam int OP_W   = 2;
   localparam int STAT_W = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

   // request codes
   localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
   localparam logic [OP_W-1:0] OP_POP  = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND = 2'd2;
   localparam logic [OP_W-1:0] OP_READ = 2'd3;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STAT_W-1:0] ST_DUP      = 3'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
   localparam logic [STAT_W-1:0] ST_RANGE    = 3'd5;

   // command bundle from the sequencer to the entry memory
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } uvs_ram_cmd_type;

endpackage

@@ sv/uvs_channels.sv @@
// valid/ready channel interfaces for request, response and capacity writes
// depends on uvs_pkg

interface uvs_req_if;
   import uvs_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          req_type;
   logic signed [DATA_W-1:0] item_value;
   logic [ADDR_W-1:0]        position;

   modport source (output valid, output req_type, output item_value, output position,
                   input ready);
   modport sink   (input valid, input req_type, input item_value, input position,
                   output ready);
endinterface

interface uvs_rsp_if;
   import uvs_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_value;
   logic [ADDR_W-1:0]        found_position;
   logic [CNT_W-1:0]         item_count;
   logic [STAT_W-1:0]        status;

   modport source (output valid, output result_value, output found_position,
                   output item_count, output status, input ready);
   modport sink   (input valid, input result_value, input found_position,
                   input item_count, input status, output ready);
endinterface

interface uvs_csr_if;
   import uvs_pkg::*;
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] capacity;

   modport source (output valid, output capacity, input ready);
   modport sink   (input valid, input capacity, output ready);
endinterface

@@ sv/uvs_entry_ram.sv @@
// entry storage: one write port, one read port with registered read data
// depends on uvs_pkg

module uvs_entry_ram (
   input  logic                           clock,
   input  uvs_pkg::uvs_ram_cmd_type       ram_cmd,
   output logic [uvs_pkg::DATA_W-1:0]     rd_data
);
   import uvs_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_cmd.wr_en) begin
         mem[ram_cmd.wr_addr] <= ram_cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_cmd.rd_en) begin
         rd_data_ff <= mem[ram_cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/unique_value_stack_top.sv @@
// top level of the unique value stack: sequencer, shared compare unit, response register
// depends on uvs_pkg, uvs_channels (interfaces) and uvs_entry_ram

// A bounded LIFO of signed 32-bit values that refuses duplicates. Each request
// transaction (push, pop, find, read) yields exactly one response transaction with
// the value, found position, entry count after the request and a status code.
// One request is worked on at a time. Pushes and finds walk the stored entries from
// the bottom through the single read port of the entry memory, one entry per cycle,
// with one equality comparator checking the word read the cycle before; the walk
// stops at the first match. A push or find therefore reads up to count entries
// between acceptance and its response, pops and reads make one memory read, and
// requests settled without the memory (full, empty, out of range, search on an
// empty stack) go straight to the done state. The response sits in an output
// register, so the next request is taken while a response still waits. Capacity
// writes are always accepted and should only be made while no request is open.
// The entry memory needs no clearing: only positions below the count are read.

module unique_value_stack_top (
   input  logic         clock,
   input  logic         reset,
   uvs_csr_if.sink      csr_chan,
   uvs_req_if.sink      req_chan,
   uvs_rsp_if.source    rsp_chan
);
   import uvs_pkg::*;

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;   // waiting for a request
   localparam logic [1:0] S_SCAN = 2'd1;   // walking entries for push or find
   localparam logic [1:0] S_LOAD = 2'd2;   // single memory read in flight
   localparam logic [1:0] S_DONE = 2'd3;   // hand result to the response register

   logic [1:0]         state_ff, state_in;
   logic [CAP_W-1:0]   capacity_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [DATA_W-1:0]  value_ff, value_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [ADDR_W-1:0]  found_ff, found_in;
   logic [DATA_W-1:0]  data_ff, data_in;

   // scan pipeline: issue index and one compare stage behind it
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [ADDR_W-1:0]  cmp_idx_ff, cmp_idx_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [ADDR_W-1:0]  rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;

   uvs_ram_cmd_type    ram_cmd;
   logic [DATA_W-1:0]  ram_rd_data;

   logic               req_fire;
   logic               out_free;
   logic [CNT_W-1:0]   limit;
   logic [CNT_W-1:0]   count_m1;
   logic               cmp_hit;
   logic               scan_done;
   logic               push_ok;
   logic               pop_ok;

   uvs_entry_ram u_entry_ram (
      .clock   (clock),
      .ram_cmd (ram_cmd),
      .rd_data (ram_rd_data)
   );

   // capacity register, always writable
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_chan.valid) begin
         capacity_ff <= csr_chan.capacity;
      end
   end

   // effective limit is the smaller of capacity and the memory depth
   assign limit = (CNT_W'(capacity_ff) < CNT_W'(DEPTH)) ? CNT_W'(capacity_ff)
                                                         : CNT_W'(DEPTH);
   assign count_m1 = count_ff - CNT_W'(1);

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // shared comparator on the word read last cycle
   assign cmp_hit   = cmp_vld_ff && (ram_rd_data == value_ff);
   assign scan_done = (issue_ff >= count_ff);

   assign push_ok = (op_ff == OP_PUSH) && (status_ff == ST_OK);
   assign pop_ok  = (op_ff == OP_POP) && (status_ff == ST_OK);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      data_in       = data_ff;
      issue_in      = issue_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      ram_cmd       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_chan.req_type;
               value_in  = req_chan.item_value;
               status_in = ST_OK;
               found_in  = '0;
               data_in   = '0;
               issue_in  = '0;
               unique case (req_chan.req_type)
                  OP_PUSH: begin
                     if (count_ff >= limit) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else if (count_ff == '0) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        ram_cmd.rd_en   = 1'b1;
                        ram_cmd.rd_addr = count_m1[ADDR_W-1:0];
                        state_in        = S_LOAD;
                     end
                  end
                  OP_FIND: begin
                     if (count_ff == '0) begin
                        status_in = ST_NOTFOUND;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_READ: begin
                     if ({1'b0, req_chan.position} >= count_ff) begin
                        status_in = ST_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        ram_cmd.rd_en   = 1'b1;
                        ram_cmd.rd_addr = req_chan.position;
                        state_in        = S_LOAD;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            // first match wins since entries are issued bottom up
            if (cmp_hit) begin
               status_in = (op_ff == OP_PUSH) ? ST_DUP : ST_OK;
               found_in  = cmp_idx_ff;
               state_in  = S_DONE;
            end else if (scan_done) begin
               status_in = (op_ff == OP_PUSH) ? ST_OK : ST_NOTFOUND;
               state_in  = S_DONE;
            end else begin
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = issue_ff[ADDR_W-1:0];
               issue_in        = issue_ff + CNT_W'(1);
               cmp_vld_in      = 1'b1;
               cmp_idx_in      = issue_ff[ADDR_W-1:0];
            end
         end
         S_LOAD: begin
            data_in  = ram_rd_data;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               // commit the stack update together with the response
               priority if (push_ok) begin
                  count_in        = count_ff + CNT_W'(1);
                  ram_cmd.wr_en   = 1'b1;
                  ram_cmd.wr_addr = count_ff[ADDR_W-1:0];
                  ram_cmd.wr_data = value_ff;
               end else if (pop_ok) begin
                  count_in = count_m1;
               end else begin
                  count_in = count_ff;
               end
               rsp_valid_in  = 1'b1;
               rsp_value_in  = ((op_ff == OP_POP || op_ff == OP_READ) && status_ff == ST_OK)
                               ? data_ff : '0;
               rsp_found_in  = (op_ff == OP_FIND && status_ff == ST_OK) ? found_ff : '0;
               rsp_count_in  = count_in;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      data_ff       <= data_in;
      issue_ff      <= issue_in;
      cmp_idx_ff    <= cmp_idx_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.result_value   = rsp_value_ff;
   assign rsp_chan.found_position = rsp_found_ff;
   assign rsp_chan.item_count     = rsp_count_ff;
   assign rsp_chan.status         = rsp_status_ff;

   // count stays within the memory depth
   a_count_in_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   // a scan is only entered with stored entries
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (count_ff != '0))
      else $error("scan with empty stack");

   // compare stage only checks stored positions
   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> ({1'b0, cmp_idx_ff} < count_ff))
      else $error("compare beyond stored entries");

   // a successful push never grows past the limit
   a_push_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && push_ok) |-> (count_ff < limit))
      else $error("push accepted at the limit");

   // an accepted request leaves idle on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("sequencer idle after acceptance");

endmodule
